FILE: sv/letterbox_detection_unmap_defines.svh
// Assertion macros shared by the letterbox unmap RTL.
`ifndef LETTERBOX_DETECTION_UNMAP_DEFINES_SVH
`define LETTERBOX_DETECTION_UNMAP_DEFINES_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define LBU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("letterbox unmap assertion failed");

// Condition must never be true outside reset.
`define LBU_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("letterbox unmap forbidden condition seen");

`else

`define LBU_ASSERT(lbl, clk, rst_n, prop)
`define LBU_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: sv/lbu_pkg.sv
// Shared widths, codes and types of the letterbox unmap block.
package lbu_pkg;

    localparam int COORD_FRAC_BITS = 4;

    localparam int COORD_W    = 17;
    localparam int SCORE_W    = 16;
    localparam int LABEL_W    = 10;
    localparam int DIM_W      = 13;
    localparam int PX_W       = 12;
    localparam int SCALE_FRAC = 16;
    localparam int SCALE_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LANES      = 4;

    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_FRAC = SCALE_FRAC + COORD_FRAC_BITS;
    localparam int PROD_W    = DIFF_W + SCALE_W + 1;
    localparam int CLAMP_W   = DIM_W + PROD_FRAC;
    localparam int DIV_NUM_W = DIM_W + PROD_FRAC;
    localparam int DIV_DEN_W = SCALE_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD = 16'd32768;
    localparam logic [DIM_W-1:0]   RST_NET_WIDTH       = 13'd640;
    localparam logic [DIM_W-1:0]   RST_NET_HEIGHT      = 13'd640;
    localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH     = 13'd640;
    localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT    = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCORE_THRESHOLD = 3'd0,
        CFG_NET_WIDTH       = 3'd1,
        CFG_NET_HEIGHT      = 3'd2,
        CFG_IMAGE_WIDTH     = 3'd3,
        CFG_IMAGE_HEIGHT    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DRV_IDLE,
        DRV_LAUNCH,
        DRV_WAIT
    } t_drv_state;

    typedef enum logic [1:0] {
        OP_RATIO_W,
        OP_RATIO_H,
        OP_PAD_X,
        OP_PAD_Y
    } t_div_op;

    typedef struct packed {
        logic [SCORE_W-1:0] thr;
        logic [DIM_W-1:0]   net_w;
        logic [DIM_W-1:0]   net_h;
        logic [DIM_W-1:0]   img_w;
        logic [DIM_W-1:0]   img_h;
    } t_cfg_regs;

    typedef struct packed {
        logic [SCALE_W-1:0]        scale;
        logic signed [COORD_W-1:0] off_x;
        logic signed [COORD_W-1:0] off_y;
    } t_xform;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_resp;

endpackage

FILE: sv/lbu_if.sv
// Channel interfaces of the letterbox unmap block: rows in, results out, register writes.
interface lbu_in_if;
    import lbu_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] corner_x0;
    logic signed [COORD_W-1:0] corner_y0;
    logic signed [COORD_W-1:0] corner_x1;
    logic signed [COORD_W-1:0] corner_y1;
    logic [SCORE_W-1:0]        row_score;
    logic [LABEL_W-1:0]        class_label;
    logic                      last_row;

    modport source (
        output valid, corner_x0, corner_y0, corner_x1, corner_y1,
               row_score, class_label, last_row,
        input  ready
    );
    modport sink (
        input  valid, corner_x0, corner_y0, corner_x1, corner_y1,
               row_score, class_label, last_row,
        output ready
    );
endinterface

interface lbu_out_if;
    import lbu_pkg::*;

    logic               valid;
    logic               ready;
    logic               kept;
    logic [LABEL_W-1:0] out_label;
    logic [SCORE_W-1:0] out_score;
    logic [PX_W-1:0]    box_left;
    logic [PX_W-1:0]    box_top;
    logic [PX_W-1:0]    box_width;
    logic [PX_W-1:0]    box_height;
    logic               frame_end;

    modport source (
        output valid, kept, out_label, out_score, box_left, box_top,
               box_width, box_height, frame_end,
        input  ready
    );
    modport sink (
        input  valid, kept, out_label, out_score, box_left, box_top,
               box_width, box_height, frame_end,
        output ready
    );
endinterface

interface lbu_cfg_if;
    import lbu_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/lbu_divider.sv
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module lbu_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lbu_pkg::t_div_req  i_req,
    output lbu_pkg::t_div_resp o_resp
);
    import lbu_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 ge;
    logic [DIV_DEN_W-1:0] n_rem;
    logic [DIV_NUM_W-1:0] n_quo;
    logic                 last_step;

    // dividend shifts out of the top of r_quo while quotient bits enter at the bottom
    always_comb begin
        rem_sh    = {r_rem, r_quo[DIV_NUM_W-1]};
        rem_sub   = rem_sh - {1'b0, r_den};
        ge        = rem_sh >= {1'b0, r_den};
        n_rem     = ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        n_quo     = {r_quo[DIV_NUM_W-2:0], ge};
        last_step = r_cnt == DIV_CNT_W'(DIV_NUM_W - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last_step;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_resp.busy = r_busy;
    assign o_resp.done = r_done;
    assign o_resp.quot = r_quo;

endmodule

FILE: sv/lbu_derive.sv
// Sequencer that works out scale and letterbox pads from the frame registers.
`include "letterbox_detection_unmap_defines.svh"

module lbu_derive (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  lbu_pkg::t_cfg_regs i_regs,
    output logic               o_busy,
    output lbu_pkg::t_xform    o_xform
);
    import lbu_pkg::*;

    localparam int PAD_W = DIV_NUM_W + 2;
    localparam logic signed [PAD_W-1:0] PAD_LO = PAD_W'(-(2 ** (COORD_W - 1)));
    localparam logic signed [PAD_W-1:0] PAD_HI = PAD_W'(2 ** (COORD_W - 1) - 1);

    t_drv_state r_state, n_state;
    t_div_op    r_op, n_op;

    logic [DIV_NUM_W-1:0]      r_ratio_w;
    logic [SCALE_W-1:0]        r_scale;
    logic signed [COORD_W-1:0] r_off_x;
    logic signed [COORD_W-1:0] r_off_y;

    t_div_req  div_req;
    t_div_resp div_resp;

    logic [DIM_W-1:0]          net_sel;
    logic [DIM_W-1:0]          img_sel;
    logic [DIV_NUM_W-1:0]      ratio_max;
    logic [SCALE_W-1:0]        n_scale;
    logic [DIV_NUM_W-1:0]      q;
    logic signed [PAD_W-1:0]   diff;
    logic signed [PAD_W-1:0]   half;
    logic signed [COORD_W-1:0] n_pad;

    lbu_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_resp (div_resp)
    );

    // operands of the current division
    always_comb begin
        if (r_op == OP_RATIO_W || r_op == OP_PAD_X) begin
            net_sel = i_regs.net_w;
            img_sel = i_regs.img_w;
        end else begin
            net_sel = i_regs.net_h;
            img_sel = i_regs.img_h;
        end
        div_req.start = r_state == DRV_LAUNCH;
        if (r_op == OP_RATIO_W || r_op == OP_RATIO_H) begin
            div_req.num = DIV_NUM_W'(img_sel) << SCALE_FRAC;
            div_req.den = (net_sel == '0) ? DIV_DEN_W'(1) : DIV_DEN_W'(net_sel);
        end else begin
            div_req.num = DIV_NUM_W'(img_sel) << PROD_FRAC;
            div_req.den = r_scale;
        end
    end

    // scale = saturated max of the two ratios; pad = floor((net - q) / 2), saturated
    always_comb begin
        ratio_max = (div_resp.quot > r_ratio_w) ? div_resp.quot : r_ratio_w;
        n_scale   = (|ratio_max[DIV_NUM_W-1:SCALE_W]) ? '1 : ratio_max[SCALE_W-1:0];
        q         = (r_scale == '0) ? '0 : div_resp.quot;
        diff      = (PAD_W'(net_sel) << COORD_FRAC_BITS) - PAD_W'(q);
        half      = diff >>> 1;
        if (half < PAD_LO) begin
            n_pad = PAD_LO[COORD_W-1:0];
        end else if (half > PAD_HI) begin
            n_pad = PAD_HI[COORD_W-1:0];
        end else begin
            n_pad = half[COORD_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        case (r_state)
            DRV_IDLE: begin
                if (i_start) begin
                    n_state = DRV_LAUNCH;
                    n_op    = OP_RATIO_W;
                end
            end
            DRV_LAUNCH: begin
                n_state = DRV_WAIT;
            end
            DRV_WAIT: begin
                if (div_resp.done) begin
                    case (r_op)
                        OP_RATIO_W: begin
                            n_op    = OP_RATIO_H;
                            n_state = DRV_LAUNCH;
                        end
                        OP_RATIO_H: begin
                            n_op    = OP_PAD_X;
                            n_state = DRV_LAUNCH;
                        end
                        OP_PAD_X: begin
                            n_op    = OP_PAD_Y;
                            n_state = DRV_LAUNCH;
                        end
                        default: begin
                            n_state = DRV_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = DRV_IDLE;
            end
        endcase
    end

    // reset starts a derivation from the reset register values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DRV_LAUNCH;
            r_op    <= OP_RATIO_W;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == DRV_WAIT && div_resp.done) begin
            case (r_op)
                OP_RATIO_W: r_ratio_w <= div_resp.quot;
                OP_RATIO_H: r_scale   <= n_scale;
                OP_PAD_X:   r_off_x   <= n_pad;
                default:    r_off_y   <= n_pad;
            endcase
        end
    end

    assign o_busy        = r_state != DRV_IDLE;
    assign o_xform.scale = r_scale;
    assign o_xform.off_x = r_off_x;
    assign o_xform.off_y = r_off_y;

    `LBU_ASSERT(a_start_when_div_free, i_clk, i_rst_n, div_req.start |-> !div_resp.busy)
    `LBU_ASSERT(a_done_only_waiting, i_clk, i_rst_n, div_resp.done |-> r_state == DRV_WAIT)
    `LBU_ASSERT(a_pad_y_ends_run, i_clk, i_rst_n, (r_state == DRV_WAIT && div_resp.done && r_op == OP_PAD_Y) |=> r_state == DRV_IDLE)

endmodule

FILE: sv/lbu_map_pipe.sv
// Four-stage row pipeline: pad removal, scaling, clamping, box formation.
`include "letterbox_detection_unmap_defines.svh"

module lbu_map_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_hold,
    input  lbu_pkg::t_cfg_regs i_regs,
    input  lbu_pkg::t_xform    i_xform,
    lbu_in_if.sink             i_in,
    lbu_out_if.source          o_out
);
    import lbu_pkg::*;

    typedef struct packed {
        logic               pass;
        logic [LABEL_W-1:0] label;
        logic [SCORE_W-1:0] score;
        logic               last;
    } t_side;

    function automatic logic [PX_W-1:0] to_px(input logic [CLAMP_W-1:0] v);
        logic [DIM_W-1:0] whole;
        whole = v[CLAMP_W-1:PROD_FRAC];
        return (|whole[DIM_W-1:PX_W]) ? '1 : whole[PX_W-1:0];
    endfunction

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    logic in_fire;

    t_side r_side1, r_side2, r_side3, r_side4;

    logic signed [COORD_W-1:0] coord [LANES];
    logic signed [DIFF_W-1:0]  n_dx  [LANES];
    logic signed [DIFF_W-1:0]  r_dx  [LANES];
    logic signed [SCALE_W:0]   scale_s;
    logic signed [PROD_W-1:0]  n_prod [LANES];
    logic signed [PROD_W-1:0]  r_prod [LANES];
    logic [DIM_W-1:0]          frame  [LANES];
    logic [CLAMP_W-1:0]        hi     [LANES];
    logic signed [PROD_W-1:0]  hi_ext [LANES];
    logic [CLAMP_W-1:0]        n_clp  [LANES];
    logic [CLAMP_W-1:0]        r_clp  [LANES];

    logic               box_ok;
    logic               n_kept;
    logic [CLAMP_W-1:0] span_w;
    logic [CLAMP_W-1:0] span_h;
    logic               r_kept;
    logic [PX_W-1:0]    r_left, r_top, r_width, r_height;

    // elastic handshake: a stage loads when empty or when its successor moves
    assign rdy4       = !r_v4 || o_out.ready;
    assign rdy3       = !r_v3 || rdy4;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign i_in.ready = rdy1 && !i_hold;
    assign in_fire    = i_in.valid && i_in.ready;

    assign coord[0] = i_in.corner_x0;
    assign coord[1] = i_in.corner_y0;
    assign coord[2] = i_in.corner_x1;
    assign coord[3] = i_in.corner_y1;
    assign scale_s  = {1'b0, i_xform.scale};

    // lanes 0 and 2 are x, lanes 1 and 3 are y
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_dx[k]   = DIFF_W'(coord[k])
                      - DIFF_W'((k % 2 == 0) ? i_xform.off_x : i_xform.off_y);
            n_prod[k] = r_dx[k] * scale_s;
            frame[k]  = (k % 2 == 0) ? i_regs.img_w : i_regs.img_h;
            hi[k]     = CLAMP_W'(frame[k] - 1'b1) << PROD_FRAC;
            hi_ext[k] = PROD_W'(hi[k]);
            if (r_prod[k][PROD_W-1] || frame[k] == '0) begin
                n_clp[k] = '0;
            end else if (r_prod[k] > hi_ext[k]) begin
                n_clp[k] = hi[k];
            end else begin
                n_clp[k] = r_prod[k][CLAMP_W-1:0];
            end
        end
    end

    always_comb begin
        box_ok = (r_clp[2] >= r_clp[0]) && (r_clp[3] >= r_clp[1]);
        n_kept = r_side3.pass && box_ok;
        span_w = r_clp[2] - r_clp[0];
        span_h = r_clp[3] - r_clp[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= in_fire;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_side1.pass  <= i_in.row_score >= i_regs.thr;
            r_side1.label <= i_in.class_label;
            r_side1.score <= i_in.row_score;
            r_side1.last  <= i_in.last_row;
            r_dx          <= n_dx;
        end
        if (rdy2 && r_v1) begin
            r_side2 <= r_side1;
            r_prod  <= n_prod;
        end
        if (rdy3 && r_v2) begin
            r_side3 <= r_side2;
            r_clp   <= n_clp;
        end
        if (rdy4 && r_v3) begin
            r_side4  <= r_side3;
            r_kept   <= n_kept;
            r_left   <= n_kept ? to_px(r_clp[0]) : '0;
            r_top    <= n_kept ? to_px(r_clp[1]) : '0;
            r_width  <= n_kept ? to_px(span_w) : '0;
            r_height <= n_kept ? to_px(span_h) : '0;
        end
    end

    assign o_out.valid      = r_v4;
    assign o_out.kept       = r_kept;
    assign o_out.out_label  = r_side4.label;
    assign o_out.out_score  = r_side4.score;
    assign o_out.box_left   = r_left;
    assign o_out.box_top    = r_top;
    assign o_out.box_width  = r_width;
    assign o_out.box_height = r_height;
    assign o_out.frame_end  = r_side4.last;

    `LBU_ASSERT_NEVER(a_hold_blocks_rows, i_clk, i_rst_n, i_hold && i_in.ready)
    `LBU_ASSERT(a_accept_fills_s1, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> r_v1)
    `LBU_ASSERT(a_reject_zero_box, i_clk, i_rst_n, (o_out.valid && !o_out.kept) |-> (o_out.box_left == '0 && o_out.box_top == '0 && o_out.box_width == '0 && o_out.box_height == '0))

endmodule

FILE: sv/letterbox_detection_unmap.sv
// Top level of the letterbox detection unmap block.
//
// Maps detector rows from network space back to frame pixels. Each row
// transaction carries four Q12.4 corners, a Q0.16 score, a class label and
// an end-of-frame flag; exactly one result transaction comes back per row,
// in order. A row is kept when its score is at least score_threshold and the
// clamped box is not inverted; rejected rows return zero box fields with
// label, score and frame_end passed through. Rows stream at one per cycle,
// when nothing holds them, through four register stages (subtract pad,
// multiply by scale, clamp to the frame, form left/top/width/height); the
// last one is the output register. Back-pressure on the output holds the
// pipeline in place; empty stages still take new rows. The scale (Q8.16)
// and the two pads are produced by one shared radix-2 divider doing four
// divisions in turn after reset and after every write to a listed
// register. During that time both the row and the register channel hold
// ready low. Writes to register indexes beyond the list complete and
// change nothing. Register writes are meant to happen only with no rows
// in flight.
module letterbox_detection_unmap (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lbu_in_if.sink    i_in,
    lbu_out_if.source o_out,
    lbu_cfg_if.sink   i_cfg
);
    import lbu_pkg::*;

    t_cfg_regs r_regs;
    t_cfg_regs n_regs;
    logic      cfg_known;
    logic      cfg_fire;
    logic      drv_busy;
    logic      row_hold;
    t_xform    xform;

    // register writes only land while the derivation is idle
    assign i_cfg.ready = !drv_busy;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;

    // no rows enter while scale and pads are being recomputed
    assign row_hold = drv_busy || i_cfg.valid;

    always_comb begin
        n_regs    = r_regs;
        cfg_known = 1'b1;
        case (t_cfg_idx'(i_cfg.index))
            CFG_SCORE_THRESHOLD: n_regs.thr   = i_cfg.data[SCORE_W-1:0];
            CFG_NET_WIDTH:       n_regs.net_w = i_cfg.data[DIM_W-1:0];
            CFG_NET_HEIGHT:      n_regs.net_h = i_cfg.data[DIM_W-1:0];
            CFG_IMAGE_WIDTH:     n_regs.img_w = i_cfg.data[DIM_W-1:0];
            CFG_IMAGE_HEIGHT:    n_regs.img_h = i_cfg.data[DIM_W-1:0];
            default:             cfg_known    = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '{thr:   RST_SCORE_THRESHOLD,
                        net_w: RST_NET_WIDTH,
                        net_h: RST_NET_HEIGHT,
                        img_w: RST_IMAGE_WIDTH,
                        img_h: RST_IMAGE_HEIGHT};
        end else if (cfg_fire) begin
            r_regs <= n_regs;
        end
    end

    // scale and pads, rerun on every write to a listed register
    lbu_derive u_derive (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(cfg_fire && cfg_known),
        .i_regs (r_regs),
        .o_busy (drv_busy),
        .o_xform(xform)
    );

    // per-row datapath
    lbu_map_pipe u_pipe (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_hold (row_hold),
        .i_regs (r_regs),
        .i_xform(xform),
        .i_in   (i_in),
        .o_out  (o_out)
    );

endmodule
